@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each use expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define SVMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define SVMD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/svmd_pkg.sv @@
package svmd_pkg;

	// table geometry
	localparam int unsigned VERTEX_COUNT = 64;
	localparam int unsigned SET_COUNT    = 16;
	localparam int unsigned VERTEX_W     = $clog2(VERTEX_COUNT);
	localparam int unsigned SET_W        = $clog2(SET_COUNT);
	localparam int unsigned ADDR_W       = SET_W + VERTEX_W;
	localparam int unsigned DEPTH        = SET_COUNT * VERTEX_COUNT;
	localparam int unsigned COST_W       = 32;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic signed [COST_W-1:0] cost_t;

	localparam addr_t LAST_ADDR = addr_t'(DEPTH - 1);
	localparam cost_t SENTINEL  = cost_t'(32'h7FFF_FFFF);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACCUM = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// clearing sweep status, driven by the sweep sequencer
	typedef struct packed {
		logic  busy;
		addr_t addr;
	} clear_t;

endpackage

@@ rtl/svmd_clear.sv @@
`include "assert_macros.svh"

module svmd_clear import svmd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output clear_t clr
);

	logic  busy_q;
	addr_t addr_q;

	// sweep every table address once; runs after reset and on each clear command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + addr_t'(1);
			if (addr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end
		end else if (start) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = addr_q;

	`SVMD_ASSERT(a_sweep_steps, busy_q && addr_q != LAST_ADDR |=> busy_q && addr_q == $past(addr_q) + addr_t'(1), "clear sweep skipped an address")

endmodule

@@ rtl/svmd_table.sv @@
`include "assert_macros.svh"

module svmd_table import svmd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  logic   lower,
	input  addr_t  addr,
	input  cost_t  cost,
	input  clear_t clr,
	output cost_t  cur_s1
);

	cost_t mem [DEPTH];

	addr_t addr_s1;
	cost_t cost_s1;
	cost_t rdata_s1;
	logic  lower_s1;

	addr_t fwd_addr_q;
	cost_t fwd_data_q;
	logic  fwd_valid_q;

	logic  wr_en;

	// memory: sweep writes take the port while clearing, else the lowering write
	always_ff @(posedge clk) begin
		if (load) begin
			rdata_s1 <= mem[addr];
		end
		if (clr.busy) begin
			mem[clr.addr] <= SENTINEL;
		end else if (wr_en) begin
			mem[addr_s1] <= cost_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1 <= addr;
			cost_s1 <= cost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_s1 <= 1'b0;
		end else begin
			lower_s1 <= load & lower;
		end
	end

	// last write, forwarded over the read that raced it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clr.busy) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= cost_s1;
		end
	end

	// current value and compare-and-replace
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			cur_s1 = fwd_data_q;
		end else begin
			cur_s1 = rdata_s1;
		end
		wr_en = lower_s1 && (cost_s1 < cur_s1);
	end

	`SVMD_ASSERT(a_no_lower_in_sweep, clr.busy |-> !lower_s1, "entry lowered while clear sweep runs")

endmodule

@@ rtl/set_vertex_min_distance_tables_core.sv @@
// Minimum-distance tables for set/vertex pairs. Items arrive on the item channel: a clear
// command restores every entry to 2147483647, an accumulate lowers the set-to-vertex entry
// at (from_set, to_vertex) and the vertex-to-set entry at (to_set, from_vertex) when cost
// is strictly smaller, and a read returns the three minima for (from_set, from_vertex) on
// the result channel. Clear and accumulate give no result. Accumulates and reads are taken
// one per cycle; each table is one 1024 x 32 memory with a read-modify-write (registered
// read into stage 1, then compare and write) and the last write forwarded, so back-to-back
// hits on one entry are exact. A read result is registered, from stage 1 into the result
// register; it stalls further input only while a held result is not taken. After reset, and
// after each clear command, a sweep writes the sentinel to all 1024 addresses, one per
// cycle, with item_ready low while it runs. The either-way minimum is the smaller of the two
// table entries, since both of its positions are lowered by the same costs as those two tables.
`include "assert_macros.svh"

module set_vertex_min_distance_tables_core import svmd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [1:0]          command,
	input  logic [VERTEX_W-1:0] from_vertex,
	input  logic [VERTEX_W-1:0] to_vertex,
	input  logic [SET_W-1:0]    from_set,
	input  logic [SET_W-1:0]    to_set,
	input  logic signed [31:0]  cost,
	output logic                result_valid,
	input  logic                result_ready,
	output logic signed [31:0]  set_to_vertex_min,
	output logic signed [31:0]  vertex_to_set_min,
	output logic signed [31:0]  either_way_min
);

	clear_t clr;

	logic  item_fire;
	logic  is_clear;
	logic  is_accum;
	logic  is_read;
	addr_t stv_addr;
	addr_t vts_addr;

	logic  read_s1;
	logic  out_free;
	logic  s1_adv;
	cost_t stv_cur_s1;
	cost_t vts_cur_s1;

	logic  result_valid_q;
	cost_t stv_min_q;
	cost_t vts_min_q;
	cost_t both_min_q;

	// command decode and table addresses
	always_comb begin
		is_clear = 1'b0;
		is_accum = 1'b0;
		is_read  = 1'b0;
		case (cmd_t'(command))
			CMD_CLEAR: is_clear = 1'b1;
			CMD_ACCUM: is_accum = 1'b1;
			CMD_READ:  is_read  = 1'b1;
			default: begin
			end
		endcase
		if (is_accum) begin
			stv_addr = {from_set, to_vertex};
			vts_addr = {to_set, from_vertex};
		end else begin
			stv_addr = {from_set, from_vertex};
			vts_addr = {from_set, from_vertex};
		end
	end

	// flow control: only a read waiting on a full result register holds stage 1
	assign out_free   = !result_valid_q || result_ready;
	assign s1_adv     = !read_s1 || out_free;
	assign item_ready = !clr.busy && s1_adv;
	assign item_fire  = item_valid && item_ready;

	svmd_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (item_fire && is_clear),
		.clr    (clr)
	);

	svmd_table u_stv_table (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (item_fire),
		.lower  (is_accum),
		.addr   (stv_addr),
		.cost   (cost),
		.clr    (clr),
		.cur_s1 (stv_cur_s1)
	);

	svmd_table u_vts_table (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (item_fire),
		.lower  (is_accum),
		.addr   (vts_addr),
		.cost   (cost),
		.clr    (clr),
		.cur_s1 (vts_cur_s1)
	);

	// stage 1 read marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_s1 <= 1'b0;
		end else if (s1_adv) begin
			read_s1 <= item_fire && is_read;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= read_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && read_s1) begin
			stv_min_q  <= stv_cur_s1;
			vts_min_q  <= vts_cur_s1;
			both_min_q <= (stv_cur_s1 < vts_cur_s1) ? stv_cur_s1 : vts_cur_s1;
		end
	end

	assign result_valid      = result_valid_q;
	assign set_to_vertex_min = stv_min_q;
	assign vertex_to_set_min = vts_min_q;
	assign either_way_min    = both_min_q;

	`SVMD_ASSERT(a_result_from_read, $rose(result_valid_q) |-> $past(read_s1), "result without a read in stage 1")
	`SVMD_ASSERT(a_clear_starts_sweep, item_fire && is_clear |=> clr.busy && !item_ready, "clear transfer did not start the sweep")
	`SVMD_ASSERT(a_held_read_blocks, read_s1 && !out_free |=> read_s1 && $stable(stv_cur_s1), "held read lost its table value")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench import svmd_pkg::*;;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         CLK_HALF     = 6;
	localparam int         RESET_CYCLES = 4;
	localparam int         STALL_LIMIT  = 10000;
	localparam int         LONG_HOLD    = 400;
	localparam int         DRAIN_CYCLES = 20;
	localparam cost_t      COST_MIN     = cost_t'(32'h8000_0000);

	typedef logic [VERTEX_W-1:0] vertex_t;
	typedef logic [SET_W-1:0]    set_t;

	typedef struct packed {
		cost_t set_to_vertex;
		cost_t vertex_to_set;
		cost_t either_way;
	} minima_t;

	// Shadow tables plus the queue of minima owed by accepted reads
	class min_distance_scoreboard;
		cost_t   set_to_vertex_tbl [DEPTH];
		cost_t   vertex_to_set_tbl [DEPTH];
		cost_t   both_ways_tbl [DEPTH];
		minima_t owed_minima [$];
		int      mismatches;

		function new();
			mismatches = 0;
			wipe();
		endfunction

		function void wipe();
			for (int k = 0; k < DEPTH; k++) begin
				set_to_vertex_tbl[k] = SENTINEL;
				vertex_to_set_tbl[k] = SENTINEL;
				both_ways_tbl[k]     = SENTINEL;
			end
		endfunction

		function int pending();
			return owed_minima.size();
		endfunction

		// update the tables for one accepted transfer on the item channel
		function void note_item(logic [1:0] cmd, vertex_t fv, vertex_t tv, set_t fs, set_t ts,
				cost_t c);
			addr_t   fwd;
			addr_t   bwd;
			addr_t   query;
			minima_t m;
			fwd   = {fs, tv};
			bwd   = {ts, fv};
			query = {fs, fv};
			case (cmd)
				CMD_CLEAR: begin
					wipe();
				end
				CMD_ACCUM: begin
					// only a strictly smaller cost replaces an entry
					if (c < set_to_vertex_tbl[fwd]) set_to_vertex_tbl[fwd] = c;
					if (c < both_ways_tbl[fwd])     both_ways_tbl[fwd] = c;
					if (c < vertex_to_set_tbl[bwd]) vertex_to_set_tbl[bwd] = c;
					if (c < both_ways_tbl[bwd])     both_ways_tbl[bwd] = c;
				end
				CMD_READ: begin
					m.set_to_vertex = set_to_vertex_tbl[query];
					m.vertex_to_set = vertex_to_set_tbl[query];
					m.either_way    = both_ways_tbl[query];
					owed_minima.push_back(m);
				end
				default: begin
					// unused code: no effect
				end
			endcase
		endfunction

		function void check_result(cost_t stv, cost_t vts, cost_t ew);
			minima_t m;
			if (owed_minima.size() == 0) begin
				mismatches++;
				$error("result transfer with no read outstanding: %0d %0d %0d", stv, vts, ew);
				return;
			end
			m = owed_minima.pop_front();
			if (stv !== m.set_to_vertex) begin
				mismatches++;
				$error("set_to_vertex_min: expected %0d, got %0d", m.set_to_vertex, stv);
			end
			if (vts !== m.vertex_to_set) begin
				mismatches++;
				$error("vertex_to_set_min: expected %0d, got %0d", m.vertex_to_set, vts);
			end
			if (ew !== m.either_way) begin
				mismatches++;
				$error("either_way_min: expected %0d, got %0d", m.either_way, ew);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  command;
	vertex_t     from_vertex;
	vertex_t     to_vertex;
	set_t        from_set;
	set_t        to_set;
	cost_t       cost;
	logic        result_valid;
	logic        result_ready;
	cost_t       set_to_vertex_min;
	cost_t       vertex_to_set_min;
	cost_t       either_way_min;

	min_distance_scoreboard sb;

	bit      quiet;
	bit      hold_request;
	bit      hold_taken;
	int      stalled_cycles;
	set_t    set_base;
	vertex_t vertex_base;
	cost_t   last_cost;

	set_vertex_min_distance_tables_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.command           (command),
		.from_vertex       (from_vertex),
		.to_vertex         (to_vertex),
		.from_set          (from_set),
		.to_set            (to_set),
		.cost              (cost),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.set_to_vertex_min (set_to_vertex_min),
		.vertex_to_set_min (vertex_to_set_min),
		.either_way_min    (either_way_min)
	);

	always #(CLK_HALF) clk = ~clk;

	// idle length: mostly none, some short, a few long
	function int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// costs lean on extremes, small values and repeats of the previous one
	function cost_t pick_cost();
		cost_t c;
		case ($urandom_range(0, 9))
			0:       c = COST_MIN;
			1:       c = SENTINEL;
			2:       c = SENTINEL - 1;
			3, 4, 5: c = cost_t'(int'($urandom_range(0, 400)) - 200);
			6, 7:    c = cost_t'($urandom);
			default: c = last_cost;
		endcase
		last_cost = c;
		return c;
	endfunction

	// mostly a narrow window so reads hit entries that were lowered
	function set_t pick_set();
		if ($urandom_range(0, 99) < 85) return set_base + set_t'($urandom_range(0, 3));
		return set_t'($urandom);
	endfunction

	function vertex_t pick_vertex();
		if ($urandom_range(0, 99) < 85) return vertex_base + vertex_t'($urandom_range(0, 7));
		return vertex_t'($urandom);
	endfunction

	task automatic send_item(input logic [1:0] cmd, input vertex_t fv, input vertex_t tv,
			input set_t fs, input set_t ts, input cost_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		command     <= cmd;
		from_vertex <= fv;
		to_vertex   <= tv;
		from_set    <= fs;
		to_set      <= ts;
		cost        <= c;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// sender stops until every owed result has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
	endtask

	task automatic random_items(input int n);
		int done;
		int r;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 999);
			if (r < 8) begin
				send_item(CMD_CLEAR, vertex_t'($urandom), vertex_t'($urandom),
					set_t'($urandom), set_t'($urandom), cost_t'($urandom));
				set_base    = set_t'($urandom);
				vertex_base = vertex_t'($urandom);
				done++;
			end else if (r < 20) begin
				// ignored code, not counted
				send_item(CMD_UNUSED, vertex_t'($urandom), vertex_t'($urandom),
					set_t'($urandom), set_t'($urandom), cost_t'($urandom));
			end else if (r < 560) begin
				send_item(CMD_ACCUM, pick_vertex(), pick_vertex(), pick_set(), pick_set(),
					pick_cost());
				done++;
			end else begin
				send_item(CMD_READ, pick_vertex(), vertex_t'($urandom), pick_set(),
					set_t'($urandom), cost_t'($urandom));
				done++;
			end
		end
	endtask

	// monitor both channels, score transfers, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(set_to_vertex_min, vertex_to_set_min, either_way_min);
			if (item_valid && item_ready)
				sb.note_item(command, from_vertex, to_vertex, from_set, to_set, cost);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// result side: random back-pressure, plus one long hold on request
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					result_ready <= 1'b1;
					@(posedge clk);
				end else begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		command        = CMD_CLEAR;
		from_vertex    = '0;
		to_vertex      = '0;
		from_set       = '0;
		to_set         = '0;
		cost           = '0;
		quiet          = 1'b1;
		hold_request   = 1'b0;
		hold_taken     = 1'b0;
		stalled_cycles = 0;
		set_base       = '0;
		vertex_base    = '0;
		last_cost      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners of the table, equal and larger costs, back-to-back hits
		send_item(CMD_READ,  6'd0,  6'd0,  4'd0,  4'd0,  '0);
		send_item(CMD_ACCUM, 6'd63, 6'd0,  4'd15, 4'd0,  SENTINEL);
		send_item(CMD_READ,  6'd0,  6'd0,  4'd15, 4'd0,  '0);
		send_item(CMD_READ,  6'd63, 6'd0,  4'd0,  4'd0,  '0);
		send_item(CMD_ACCUM, 6'd63, 6'd0,  4'd15, 4'd0,  -32'sd1);
		send_item(CMD_READ,  6'd0,  6'd0,  4'd15, 4'd0,  '0);
		send_item(CMD_READ,  6'd63, 6'd0,  4'd0,  4'd0,  '0);
		send_item(CMD_ACCUM, 6'd63, 6'd0,  4'd15, 4'd0,  -32'sd1);
		send_item(CMD_ACCUM, 6'd63, 6'd0,  4'd15, 4'd0,  32'sd7);
		send_item(CMD_ACCUM, 6'd0,  6'd63, 4'd0,  4'd15, COST_MIN);
		send_item(CMD_READ,  6'd63, 6'd0,  4'd0,  4'd0,  '0);
		send_item(CMD_READ,  6'd0,  6'd0,  4'd15, 4'd0,  '0);
		send_item(CMD_ACCUM, 6'd5,  6'd5,  4'd3,  4'd3,  SENTINEL - 1);
		send_item(CMD_READ,  6'd5,  6'd0,  4'd3,  4'd0,  '0);
		send_item(CMD_UNUSED, 6'd63, 6'd63, 4'd15, 4'd15, -32'sd1);
		send_item(CMD_READ,  6'd0,  6'd0,  4'd15, 4'd0,  '0);
		quiet = 1'b0;
		send_item(CMD_CLEAR, 6'd0,  6'd0,  4'd0,  4'd0,  '0);
		send_item(CMD_READ,  6'd0,  6'd0,  4'd15, 4'd0,  '0);
		send_item(CMD_READ,  6'd63, 6'd0,  4'd0,  4'd0,  '0);
		send_item(CMD_ACCUM, 6'd42, 6'd21, 4'd10, 4'd5,  32'sd12345);
		send_item(CMD_READ,  6'd21, 6'd0,  4'd10, 4'd0,  '0);
		send_item(CMD_READ,  6'd42, 6'd0,  4'd5,  4'd0,  '0);
		wait_drained();

		// random traffic
		set_base    = set_t'($urandom);
		vertex_base = vertex_t'($urandom);
		random_items(300);

		// reads keep coming while the result side holds off, so the block backs up
		quiet        = 1'b1;
		hold_request = 1'b1;
		repeat (30)
			send_item(CMD_READ, pick_vertex(), vertex_t'($urandom), pick_set(),
				set_t'($urandom), cost_t'($urandom));
		quiet = 1'b0;
		random_items(300);
		wait_drained();

		// a stretch with no idling on either side
		quiet = 1'b1;
		random_items(100);
		quiet = 1'b0;
		random_items(370);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
